[rtl/core/mat_pkg.sv]
// ----------------------------------------------------------------------------
// mat_pkg
// Types and constants shared by the alarm timer bank core, its controller
// and its datapath.
// ----------------------------------------------------------------------------
package mat_pkg;

    // Fixed field widths of the item and result beats and of the tick step
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned TIME_W   = 20;
    localparam int unsigned TAG_W    = 16;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned STEP_W   = 10;

    // Tick step after reset
    localparam logic [STEP_W-1:0] TICK_STEP_RST = 10'd10;

    // Cap on expiries reported by one tick
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_NONE  = 2'd3
    } t_mat_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_STARTED  = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_STOPPED  = 3'd2,
        KIND_INACTIVE = 3'd3,
        KIND_EXPIRED  = 3'd4
    } t_mat_kind;

    typedef struct packed {
        t_mat_op            opcode;
        logic [SLOT_W-1:0]  slot_id;
        logic [TIME_W-1:0]  timeout_ms;
        logic [TAG_W-1:0]   callback_tag;
    } t_mat_in;

    typedef struct packed {
        t_mat_kind          kind;
        logic [SLOT_W-1:0]  slot_num;
        logic [TIME_W-1:0]  elapsed_ms;
        logic [TAG_W-1:0]   tag_out;
        logic               last;
    } t_mat_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_START,
        ST_STOP_RD,
        ST_STOP_WB,
        ST_TICK_RD,
        ST_TICK_EV,
        ST_TICK_END
    } t_mat_state;

    // Controller -> datapath
    typedef struct packed {
        logic load_item;   // capture item, clear slot index and expiry count
        logic mem_rd;      // read slot memories
        logic rd_stop;     // read address is the stop slot, else the scan index
        logic idx_inc;     // advance scan index
        logic start_claim; // claim slot at scan index, emit started
        logic emit_full;   // emit bank full
        logic stop_fin;    // emit stopped or inactive, free slot
        logic tick_apply;  // expire or count down slot at scan index
        logic push_last;   // move held expiry to output, marked last
    } t_mat_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_mat_op opcode;
        logic    cur_active; // slot at scan index is active
        logic    idx_last;   // scan index is the top slot
        logic    out_free;   // output register can take a beat this cycle
        logic    pend_vld;   // an expiry is held back
        logic    exp_hit;    // slot at scan index expires on this tick
    } t_mat_stat;

endpackage

[rtl/core/multi_slot_alarm_timer_core.sv]
// Steps: start scans for the lowest free slot, one slot a cycle; stop reads
//   the slot then writes back; tick reads then updates each slot in turn.
// Throughput: one item at a time; the next item is taken on return to idle,
//   while the last result beat may still wait in the output register.
// Reset (synchronous, active low): all slots free, tick step 10, no beat held.
//   Slot memories are not cleared; a slot is always written before its data is used.
// ----------------------------------------------------------------------------
// multi_slot_alarm_timer_core
// Bank of one-shot alarm slots. Start claims the lowest free slot (or reports
// the bank full), stop frees an active slot and reports elapsed time, tick
// counts every active slot down and reports expiries in slot order.
// ----------------------------------------------------------------------------
module multi_slot_alarm_timer_core #(
    parameter int unsigned NUM_SLOTS = 16,
    parameter int unsigned TIME_BITS = 20,
    parameter int unsigned TAG_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // item channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  mat_pkg::t_mat_in           i_in_data,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output mat_pkg::t_mat_out          o_out_data,
    // tick step register
    input  logic                       i_cfg_we,
    input  logic [mat_pkg::STEP_W-1:0] i_cfg_wdata
);
    import mat_pkg::*;

    // Controller sequences each item; datapath holds all slot state.
    // A tick holds back each expiry beat until the next one (or the end of
    // the sweep) is found, so the final beat can carry the last flag.
    t_mat_cmd  cmd;
    t_mat_stat stat;

    mat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mat_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[rtl/core/mat_ctrl.sv]
// ----------------------------------------------------------------------------
// mat_ctrl
// Sequencer of the alarm timer bank: decodes the item, runs the free-slot
// scan, the stop read and the tick sweep.
// ----------------------------------------------------------------------------
module mat_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mat_pkg::t_mat_stat i_stat,
    output mat_pkg::t_mat_cmd  o_cmd
);
    import mat_pkg::*;

    t_mat_state r_state;
    t_mat_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_stat.opcode)
                    OP_TICK:  n_state = ST_TICK_RD;
                    OP_START: n_state = ST_START;
                    OP_STOP:  n_state = ST_STOP_RD;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_START: begin
                if (!i_stat.cur_active) begin
                    if (i_stat.out_free) begin
                        o_cmd.start_claim = 1'b1;
                        n_state           = ST_IDLE;
                    end
                end else if (i_stat.idx_last) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_full = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_STOP_RD: begin
                o_cmd.mem_rd  = 1'b1;
                o_cmd.rd_stop = 1'b1;
                n_state       = ST_STOP_WB;
            end
            ST_STOP_WB: begin
                if (i_stat.out_free) begin
                    o_cmd.stop_fin = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_TICK_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_TICK_EV;
            end
            ST_TICK_EV: begin
                // a second expiry pushes the held one out; wait for room
                if (!(i_stat.exp_hit && i_stat.pend_vld && !i_stat.out_free)) begin
                    o_cmd.tick_apply = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = ST_TICK_END;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_TICK_RD;
                    end
                end
            end
            ST_TICK_END: begin
                if (!i_stat.pend_vld) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.push_last = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/mat_datapath.sv]
// ----------------------------------------------------------------------------
// mat_datapath
// Slot memories, active bits, scan index, tick step register, held expiry
// and the output register of the alarm timer bank.
// ----------------------------------------------------------------------------
module mat_datapath #(
    parameter int unsigned NUM_SLOTS = 16,
    parameter int unsigned TIME_BITS = 20,
    parameter int unsigned TAG_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mat_pkg::t_mat_in             i_in_data,
    input  logic                         i_cfg_we,
    input  logic [mat_pkg::STEP_W-1:0]   i_cfg_wdata,
    input  mat_pkg::t_mat_cmd            i_cmd,
    output mat_pkg::t_mat_stat           o_stat,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output mat_pkg::t_mat_out            o_out_data
);
    import mat_pkg::*;

    localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // slot data: undefined until written, only used while the slot is active
    logic [TIME_BITS-1:0] r_rem_mem   [NUM_SLOTS];
    logic [TIME_BITS-1:0] r_start_mem [NUM_SLOTS];
    logic [TAG_BITS-1:0]  r_tag_mem   [NUM_SLOTS];

    logic [TIME_BITS-1:0] r_rd_rem;
    logic [TIME_BITS-1:0] r_rd_start;
    logic [TAG_BITS-1:0]  r_rd_tag;

    t_mat_in              r_item;
    logic [IW-1:0]        r_idx;
    logic [CNT_W-1:0]     r_cnt;
    logic [NUM_SLOTS-1:0] r_active;
    logic [NUM_SLOTS-1:0] n_active;
    logic [STEP_W-1:0]    r_tick_step;
    t_mat_out             r_pend;
    logic                 r_pend_vld;
    t_mat_out             r_out;
    logic                 r_out_vld;

    logic [IW+SLOT_W-1:0] stop_ext;
    logic [IW-1:0]        stop_addr;
    logic                 stop_in_range;
    logic                 stop_hit;
    logic [IW-1:0]        rd_addr;
    logic                 cur_active;
    logic                 out_free;
    logic                 exp_hit;
    logic [32:0]          rem_x;
    logic [32:0]          step_x;
    logic [TIME_BITS-1:0] rem_dec;
    logic                 load_out;
    t_mat_out             n_out;
    t_mat_out             exp_res;

    assign stop_ext      = {{IW{1'b0}}, r_item.slot_id};
    assign stop_addr     = stop_ext[IW-1:0];
    assign stop_in_range = (32'(r_item.slot_id) < 32'(NUM_SLOTS));
    assign stop_hit      = stop_in_range && r_active[stop_addr];
    assign rd_addr       = i_cmd.rd_stop ? stop_addr : r_idx;
    assign cur_active    = r_active[r_idx];
    assign out_free      = !r_out_vld || i_out_ready;
    assign exp_hit       = cur_active && (r_rd_rem == '0)
                           && (r_cnt < CNT_W'(MAX_RESULTS));

    // saturating count-down
    assign rem_x   = 33'(r_rd_rem);
    assign step_x  = 33'(r_tick_step);
    assign rem_dec = (rem_x > step_x) ? TIME_BITS'(rem_x - step_x) : '0;

    assign exp_res = '{kind: KIND_EXPIRED, slot_num: SLOT_W'(r_idx), elapsed_ms: '0,
                       tag_out: TAG_W'(r_rd_tag), last: 1'b0};

    assign o_stat = '{opcode: r_item.opcode, cur_active: cur_active,
                      idx_last: (r_idx == IW'(NUM_SLOTS - 1)), out_free: out_free,
                      pend_vld: r_pend_vld, exp_hit: exp_hit};

    // next output beat
    always_comb begin
        load_out = 1'b0;
        n_out    = '0;
        if (i_cmd.start_claim) begin
            load_out       = 1'b1;
            n_out.kind     = KIND_STARTED;
            n_out.slot_num = SLOT_W'(r_idx);
            n_out.last     = 1'b1;
        end else if (i_cmd.emit_full) begin
            load_out   = 1'b1;
            n_out.kind = KIND_FULL;
            n_out.last = 1'b1;
        end else if (i_cmd.stop_fin) begin
            load_out       = 1'b1;
            n_out.slot_num = r_item.slot_id;
            n_out.last     = 1'b1;
            if (stop_hit) begin
                n_out.kind       = KIND_STOPPED;
                n_out.elapsed_ms = TIME_W'(r_rd_start - r_rd_rem);
            end else begin
                n_out.kind = KIND_INACTIVE;
            end
        end else if (i_cmd.tick_apply && exp_hit && r_pend_vld) begin
            load_out = 1'b1;
            n_out    = r_pend;
        end else if (i_cmd.push_last) begin
            load_out   = 1'b1;
            n_out      = r_pend;
            n_out.last = 1'b1;
        end
    end

    always_comb begin
        n_active = r_active;
        if (i_cmd.start_claim) begin
            n_active[r_idx] = 1'b1;
        end
        if (i_cmd.stop_fin && stop_hit) begin
            n_active[stop_addr] = 1'b0;
        end
        if (i_cmd.tick_apply && exp_hit) begin
            n_active[r_idx] = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_tick_step <= TICK_STEP_RST;
            r_pend_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
        end else begin
            r_active <= n_active;
            if (i_cfg_we) begin
                r_tick_step <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.load_item) begin
                r_idx <= '0;
                r_cnt <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.tick_apply && exp_hit) begin
                r_pend_vld <= 1'b1;
                r_cnt      <= r_cnt + 1'b1;
            end else if (i_cmd.push_last) begin
                r_pend_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (load_out) begin
            r_out <= n_out;
        end
        if (i_cmd.tick_apply && exp_hit) begin
            r_pend <= exp_res;
        end
    end

    // slot memories: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd_rem   <= r_rem_mem[rd_addr];
            r_rd_start <= r_start_mem[rd_addr];
            r_rd_tag   <= r_tag_mem[rd_addr];
        end
        if (i_cmd.start_claim) begin
            r_rem_mem[r_idx]   <= TIME_BITS'(r_item.timeout_ms);
            r_start_mem[r_idx] <= TIME_BITS'(r_item.timeout_ms);
            r_tag_mem[r_idx]   <= TAG_BITS'(r_item.callback_tag);
        end else if (i_cmd.tick_apply && cur_active && !exp_hit) begin
            r_rem_mem[r_idx] <= rem_dec;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
